[hw/rtl/spci_pkg.sv]
// shared types, command codes and constants of the svg path command interpreter
package spci_pkg;

  // default coordinate width (signed fixed point, fraction bits do not matter for sums)
  localparam int COORD_WIDTH = 32;

  // stream payload layout
  localparam int IN_TDATA_W  = 40;
  localparam int TOKEN_W     = 32;
  localparam int OUT_COORD_W = 32;
  localparam int OUT_TDATA_W = 6 * OUT_COORD_W;
  localparam int SEG_KIND_W  = 3;

  // argument buffer entries and job queue entries (queue depth a power of two)
  localparam int NUM_ARGS    = 6;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [3:0] cmd_t;
  typedef logic [2:0] arg_cnt_t;
  typedef logic [SEG_KIND_W-1:0] seg_kind_t;

  // command letter codes
  localparam cmd_t CMD_M    = 4'd0;
  localparam cmd_t CMD_L    = 4'd1;
  localparam cmd_t CMD_H    = 4'd2;
  localparam cmd_t CMD_V    = 4'd3;
  localparam cmd_t CMD_C    = 4'd4;
  localparam cmd_t CMD_S    = 4'd5;
  localparam cmd_t CMD_Q    = 4'd6;
  localparam cmd_t CMD_T    = 4'd7;
  localparam cmd_t CMD_A    = 4'd8;
  localparam cmd_t CMD_Z    = 4'd9;
  localparam cmd_t CMD_NONE = 4'd15;

  // segment kinds on the result channel
  localparam seg_kind_t SEG_MOVE  = 3'd1;
  localparam seg_kind_t SEG_LINE  = 3'd2;
  localparam seg_kind_t SEG_CUBIC = 3'd3;
  localparam seg_kind_t SEG_QUAD  = 3'd4;
  localparam seg_kind_t SEG_CLOSE = 3'd5;

  // control part of one job handed from front to back
  typedef struct packed {
    cmd_t cmd;   // command to carry out
    logic rel;   // relative coordinates
    logic refl;  // reflect the last control point (s after c/s, t after q/t)
    logic last;  // final token of the stream: back state returns to reset afterwards
    logic emit;  // a segment is produced
  } job_ctrl_t;

  // number of arguments each command collects
  function automatic arg_cnt_t arg_need(input cmd_t c);
    arg_cnt_t n;
    case (c)
      CMD_M, CMD_L, CMD_T: n = 3'd2;
      CMD_H, CMD_V:        n = 3'd1;
      CMD_C:               n = 3'd6;
      CMD_S, CMD_Q:        n = 3'd4;
      CMD_A:               n = 3'd7;
      default:             n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

[hw/rtl/spci_queue.sv]
// small register queue of jobs between the token front end and the segment back end
module spci_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = spci_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  // handshake on both sides
  assign push_ready = (count_r != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers wrap naturally since the depth is a power of two
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/spci_front.sv]
// token front end: tracks the active command, gathers arguments and issues jobs
module spci_front #(
  parameter int COORD_WIDTH = spci_pkg::COORD_WIDTH
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  input  logic [spci_pkg::IN_TDATA_W-1:0]                   in_tdata,
  input  logic [0:0]                                        in_tuser,
  input  logic                                              in_tlast,
  output logic                                              job_valid,
  input  logic                                              job_ready,
  output spci_pkg::job_ctrl_t                               job_ctrl,
  output logic [spci_pkg::NUM_ARGS-1:0][COORD_WIDTH-1:0]    job_args
);

  localparam int CW = COORD_WIDTH;
  localparam int NA = spci_pkg::NUM_ARGS;

  typedef logic signed [CW-1:0] coord_t;

  // token fields
  logic                  tok_kind;
  spci_pkg::cmd_t        tok_letter;
  logic                  tok_rel;
  logic signed [31:0]    tok_value;
  logic                  tok_acc;
  coord_t                val_c;

  assign tok_kind   = in_tuser[0];
  assign tok_letter = in_tdata[3:0];
  assign tok_rel    = in_tdata[4];
  assign tok_value  = signed'(in_tdata[spci_pkg::TOKEN_W+4:5]);
  assign in_tready  = job_ready;
  assign tok_acc    = in_tvalid && in_tready;

  // input number clamped to the coordinate range
  if (CW >= 32) begin : g_wide
    assign val_c = CW'(tok_value);
  end else begin : g_narrow
    logic [32-CW:0] upper;
    assign upper = tok_value[31:CW-1];
    assign val_c = ((&upper) || !(|upper)) ? tok_value[CW-1:0] :
                   (tok_value[31] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});
  end

  // command state
  spci_pkg::cmd_t     act_r, act_nxt;
  logic               rel_r, rel_nxt;
  logic               pend_r, pend_nxt;
  spci_pkg::arg_cnt_t cnt_r, cnt_nxt;
  spci_pkg::cmd_t     prev_r, prev_nxt;
  coord_t             buf_r [NA];

  logic               store;
  coord_t             store_val;
  spci_pkg::arg_cnt_t cnt_base;
  spci_pkg::arg_cnt_t written;
  spci_pkg::arg_cnt_t slot;
  logic [3:0]         cnt_inc;
  logic               exec;

  // buffer slot for the k-th argument; an arc keeps only its end point
  function automatic spci_pkg::arg_cnt_t slot_of(input spci_pkg::cmd_t c,
                                                  input spci_pkg::arg_cnt_t k);
    spci_pkg::arg_cnt_t s;
    if (c == spci_pkg::CMD_A) begin
      s = (k >= 3'd5) ? k - 3'd5 : 3'd6;
    end else begin
      s = k;
    end
    return s;
  endfunction

  // slots already filled once k arguments have been taken
  function automatic spci_pkg::arg_cnt_t filled_of(input spci_pkg::cmd_t c,
                                                    input spci_pkg::arg_cnt_t k);
    spci_pkg::arg_cnt_t s;
    if (c == spci_pkg::CMD_A) begin
      s = (k >= 3'd5) ? k - 3'd5 : 3'd0;
    end else begin
      s = k;
    end
    return s;
  endfunction

  // token decode and job build
  always_comb begin
    act_nxt   = act_r;
    rel_nxt   = rel_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    prev_nxt  = prev_r;
    store     = 1'b0;
    store_val = '0;
    cnt_base  = '0;
    written   = '0;
    cnt_inc   = '0;
    exec      = 1'b0;

    if (pend_r) begin
      // argument expected: a letter here counts as zero
      store     = 1'b1;
      store_val = tok_kind ? coord_t'(0) : val_c;
      cnt_base  = cnt_r;
      written   = filled_of(act_r, cnt_r);
      cnt_inc   = {1'b0, cnt_r} + 4'd1;
      cnt_nxt   = cnt_inc[2:0];
      exec      = (cnt_inc >= {1'b0, spci_pkg::arg_need(act_r)});
    end else if (tok_kind) begin
      // new command letter
      act_nxt = tok_letter;
      rel_nxt = tok_rel;
      cnt_nxt = '0;
      if (tok_letter <= spci_pkg::CMD_A) begin
        pend_nxt = 1'b1;
      end else if (tok_letter == spci_pkg::CMD_Z) begin
        exec = 1'b1;
      end else begin
        prev_nxt = tok_letter;
      end
    end else if (act_r <= spci_pkg::CMD_A) begin
      // implicit repeat of the active command
      pend_nxt  = 1'b1;
      store     = 1'b1;
      store_val = val_c;
      cnt_nxt   = 3'd1;
      exec      = (spci_pkg::arg_need(act_r) <= 3'd1);
    end

    // end of stream: missing arguments are zero
    if (in_tlast && pend_nxt && !exec) begin
      exec = 1'b1;
    end

    job_ctrl.cmd  = act_nxt;
    job_ctrl.rel  = rel_nxt;
    job_ctrl.refl = ((act_nxt == spci_pkg::CMD_S) &&
                     ((prev_r == spci_pkg::CMD_C) || (prev_r == spci_pkg::CMD_S))) ||
                    ((act_nxt == spci_pkg::CMD_T) &&
                     ((prev_r == spci_pkg::CMD_Q) || (prev_r == spci_pkg::CMD_T)));
    job_ctrl.last = in_tlast;
    job_ctrl.emit = exec;

    if (exec) begin
      prev_nxt = act_nxt;
      pend_nxt = 1'b0;
      cnt_nxt  = '0;
      if (act_nxt == spci_pkg::CMD_M) begin
        act_nxt = spci_pkg::CMD_L;
      end
    end

    // arguments with the current token forwarded, unfilled ones zero
    slot = slot_of(act_r, cnt_base);
    for (int i = 0; i < NA; i++) begin
      if (store && (slot == 3'(i))) begin
        job_args[i] = store_val;
      end else if (3'(i) < written) begin
        job_args[i] = buf_r[i];
      end else begin
        job_args[i] = '0;
      end
    end

    // last token returns everything to reset
    if (in_tlast) begin
      act_nxt  = spci_pkg::CMD_NONE;
      rel_nxt  = 1'b0;
      pend_nxt = 1'b0;
      cnt_nxt  = '0;
      prev_nxt = spci_pkg::CMD_NONE;
    end
  end

  assign job_valid = tok_acc && (exec || in_tlast);

  // command state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= spci_pkg::CMD_NONE;
      rel_r  <= 1'b0;
      pend_r <= 1'b0;
      cnt_r  <= '0;
      prev_r <= spci_pkg::CMD_NONE;
    end else if (tok_acc) begin
      act_r  <= act_nxt;
      rel_r  <= rel_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      prev_r <= prev_nxt;
    end
  end

  // argument buffer
  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      if (tok_acc && store && (slot == 3'(i))) begin
        buf_r[i] <= store_val;
      end
    end
  end

endmodule

[hw/rtl/spci_back.sv]
// segment back end: pen position, subpath start, control reflection and result register
module spci_back #(
  parameter int COORD_WIDTH = spci_pkg::COORD_WIDTH
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              job_valid,
  output logic                                              job_ready,
  input  spci_pkg::job_ctrl_t                               job_ctrl,
  input  logic [spci_pkg::NUM_ARGS-1:0][COORD_WIDTH-1:0]    job_args,
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  output logic [spci_pkg::OUT_TDATA_W-1:0]                  out_tdata,
  output logic [spci_pkg::SEG_KIND_W-1:0]                   out_tuser,
  output logic                                              out_tlast
);

  localparam int CW = COORD_WIDTH;
  localparam int OW = (CW > spci_pkg::OUT_COORD_W) ? CW : spci_pkg::OUT_COORD_W;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? CMIN : CMAX;
    end
    return s[CW-1:0];
  endfunction

  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    logic signed [CW:0] s;
    s = {a[CW-1], a} - {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      return s[CW] ? CMIN : CMAX;
    end
    return s[CW-1:0];
  endfunction

  // coordinate to the 32-bit result field
  function automatic logic [spci_pkg::OUT_COORD_W-1:0] to_out(input coord_t x);
    logic signed [OW-1:0] t;
    t = OW'(x);
    return t[spci_pkg::OUT_COORD_W-1:0];
  endfunction

  // pen state
  coord_t cx_r, cx_nxt, cy_r, cy_nxt;
  coord_t sx_r, sx_nxt, sy_r, sy_nxt;
  coord_t lcx_r, lcx_nxt, lcy_r, lcy_nxt;
  // pen minus last control, registered from the pen and control registers after each segment
  coord_t dx_r, dy_r;
  logic   d_ok_r;

  logic   out_valid_r;
  logic   [spci_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic   [spci_pkg::SEG_KIND_W-1:0]  out_kind_r;
  logic   out_last_r;

  logic   out_room, take;
  coord_t ax0, ax1, ax2, ay0, ay1, ay2, vy, rx, ry;
  coord_t c1x, c1y, c2x, c2y, ex, ey;
  spci_pkg::seg_kind_t kind;

  assign out_room  = !out_valid_r || out_tready;
  assign take      = job_valid && out_room && (!job_ctrl.refl || d_ok_r);
  assign job_ready = take;

  // relative offsets applied to the pen position
  always_comb begin
    ax0 = job_ctrl.rel ? sat_add(cx_r, coord_t'(job_args[0])) : coord_t'(job_args[0]);
    ay0 = job_ctrl.rel ? sat_add(cy_r, coord_t'(job_args[1])) : coord_t'(job_args[1]);
    ax1 = job_ctrl.rel ? sat_add(cx_r, coord_t'(job_args[2])) : coord_t'(job_args[2]);
    ay1 = job_ctrl.rel ? sat_add(cy_r, coord_t'(job_args[3])) : coord_t'(job_args[3]);
    ax2 = job_ctrl.rel ? sat_add(cx_r, coord_t'(job_args[4])) : coord_t'(job_args[4]);
    ay2 = job_ctrl.rel ? sat_add(cy_r, coord_t'(job_args[5])) : coord_t'(job_args[5]);
    vy  = job_ctrl.rel ? sat_add(cy_r, coord_t'(job_args[0])) : coord_t'(job_args[0]);
    rx  = job_ctrl.refl ? sat_add(cx_r, dx_r) : cx_r;
    ry  = job_ctrl.refl ? sat_add(cy_r, dy_r) : cy_r;
  end

  // segment per command
  always_comb begin
    c1x  = '0;
    c1y  = '0;
    c2x  = '0;
    c2y  = '0;
    ex   = ax0;
    ey   = ay0;
    kind = spci_pkg::SEG_LINE;
    lcx_nxt = lcx_r;
    lcy_nxt = lcy_r;
    case (job_ctrl.cmd)
      spci_pkg::CMD_M, spci_pkg::CMD_L, spci_pkg::CMD_A: begin
        ex   = ax0;
        ey   = ay0;
        kind = (job_ctrl.cmd == spci_pkg::CMD_M) ? spci_pkg::SEG_MOVE : spci_pkg::SEG_LINE;
        lcx_nxt = ex;
        lcy_nxt = ey;
      end
      spci_pkg::CMD_H: begin
        ex = ax0;
        ey = cy_r;
        lcx_nxt = ex;
        lcy_nxt = ey;
      end
      spci_pkg::CMD_V: begin
        ex = cx_r;
        ey = vy;
        lcx_nxt = ex;
        lcy_nxt = ey;
      end
      spci_pkg::CMD_C: begin
        c1x  = ax0;
        c1y  = ay0;
        c2x  = ax1;
        c2y  = ay1;
        ex   = ax2;
        ey   = ay2;
        kind = spci_pkg::SEG_CUBIC;
        lcx_nxt = c2x;
        lcy_nxt = c2y;
      end
      spci_pkg::CMD_S: begin
        c1x  = rx;
        c1y  = ry;
        c2x  = ax0;
        c2y  = ay0;
        ex   = ax1;
        ey   = ay1;
        kind = spci_pkg::SEG_CUBIC;
        lcx_nxt = c2x;
        lcy_nxt = c2y;
      end
      spci_pkg::CMD_Q: begin
        c1x  = ax0;
        c1y  = ay0;
        ex   = ax1;
        ey   = ay1;
        kind = spci_pkg::SEG_QUAD;
        lcx_nxt = c1x;
        lcy_nxt = c1y;
      end
      spci_pkg::CMD_T: begin
        c1x  = rx;
        c1y  = ry;
        ex   = ax0;
        ey   = ay0;
        kind = spci_pkg::SEG_QUAD;
        lcx_nxt = c1x;
        lcy_nxt = c1y;
      end
      default: begin
        // close back to the subpath start
        ex   = sx_r;
        ey   = sy_r;
        kind = spci_pkg::SEG_CLOSE;
        lcx_nxt = ex;
        lcy_nxt = ey;
      end
    endcase
  end

  // pen state next values
  always_comb begin
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    if (take && job_ctrl.emit) begin
      cx_nxt = ex;
      cy_nxt = ey;
      if (job_ctrl.cmd == spci_pkg::CMD_M) begin
        sx_nxt = ex;
        sy_nxt = ey;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      lcx_r  <= '0;
      lcy_r  <= '0;
      d_ok_r <= 1'b0;
    end else if (take && job_ctrl.last) begin
      // stream finished
      cx_r   <= '0;
      cy_r   <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      lcx_r  <= '0;
      lcy_r  <= '0;
      d_ok_r <= 1'b0;
    end else begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      if (take && job_ctrl.emit) begin
        lcx_r <= lcx_nxt;
        lcy_r <= lcy_nxt;
      end
      d_ok_r <= !(take && job_ctrl.emit);
    end
  end

  // reflection difference from the settled pen state
  always_ff @(posedge clk) begin
    dx_r <= sat_sub(cx_r, lcx_r);
    dy_r <= sat_sub(cy_r, lcy_r);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && job_ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && job_ctrl.emit) begin
      out_data_r <= {to_out(ey), to_out(ex), to_out(c2y), to_out(c2x),
                     to_out(c1y), to_out(c1x)};
      out_kind_r <= kind;
      out_last_r <= job_ctrl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

[hw/rtl/svg_path_command_interpreter.sv]
// a segment passes from the token completing it through the job queue and the result register to out_*
// throughput: one token per cycle while the job queue has room; an s or t that reflects and
//   reaches the back end right behind the segment before it waits for the pen-minus-control difference
// a two-entry job queue parts the token front end from the segment back end
// reset: synchronous rst_n low clears pen, subpath and command state; no clearing pass
module svg_path_command_interpreter #(
  parameter int COORD_WIDTH = spci_pkg::COORD_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // token channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [spci_pkg::IN_TDATA_W-1:0]    in_tdata,   // letter[3:0], relative[4], value[36:5]
  input  logic [0:0]                         in_tuser,   // kind[0]
  input  logic                               in_tlast,   // last_token
  // segment channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [spci_pkg::OUT_TDATA_W-1:0]   out_tdata,  // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                                                         // end_x, end_y (32 bits each)
  output logic [spci_pkg::SEG_KIND_W-1:0]    out_tuser,  // seg_kind[2:0]
  output logic                               out_tlast   // stream_end
);

  localparam int NA    = spci_pkg::NUM_ARGS;
  localparam int JOB_W = NA * COORD_WIDTH + $bits(spci_pkg::job_ctrl_t);

  spci_pkg::job_ctrl_t                 push_ctrl, pop_ctrl;
  logic [NA-1:0][COORD_WIDTH-1:0]      push_args, pop_args;
  logic                                push_valid, push_ready;
  logic                                pop_valid, pop_ready;
  logic [JOB_W-1:0]                    push_data, pop_data;

  // token decode and argument gathering
  spci_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job_ctrl  (push_ctrl),
    .job_args  (push_args)
  );

  // job queue
  assign push_data = {push_args, push_ctrl};

  spci_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_ctrl = pop_data[$bits(spci_pkg::job_ctrl_t)-1:0];
  assign pop_args = pop_data[JOB_W-1:$bits(spci_pkg::job_ctrl_t)];

  // segment generation
  spci_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (pop_valid),
    .job_ready  (pop_ready),
    .job_ctrl   (pop_ctrl),
    .job_args   (pop_args),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/spci_segment_checker.sv]
// segment scoreboard of the svg path command interpreter: predicts each segment and checks it
module spci_segment_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [spci_pkg::IN_TDATA_W-1:0]  in_tdata,   // letter[3:0], relative[4], value[36:5]
  input  logic [0:0]                       in_tuser,   // kind[0]
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [spci_pkg::OUT_TDATA_W-1:0] out_tdata,  // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                                                       // end_x, end_y
  input  logic [spci_pkg::SEG_KIND_W-1:0]  out_tuser,  // seg_kind[2:0]
  input  logic                             out_tlast,
  output int                               fail_count,
  output int                               seg_waiting,
  output int                               seg_checked
);

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    spci_pkg::seg_kind_t kind;
    coord_t              c1x;
    coord_t              c1y;
    coord_t              c2x;
    coord_t              c2y;
    coord_t              ex;
    coord_t              ey;
    logic                stream_end;
  } segment_t;

  localparam longint COORD_TOP    = 64'sd2147483647;
  localparam longint COORD_BOTTOM = -64'sd2147483648;

  // pen, subpath and command state of the interpreter
  coord_t             pen_x, pen_y, start_x, start_y, ctl_x, ctl_y;
  spci_pkg::cmd_t     cur_cmd, prev_cmd;
  logic               cur_rel, collecting;
  spci_pkg::arg_cnt_t n_args;
  coord_t             arg_buf [spci_pkg::NUM_ARGS];

  segment_t seg_q [$];
  segment_t want;

  function automatic coord_t saturate(input longint s);
    if (s > COORD_TOP) return 32'sh7FFFFFFF;
    if (s < COORD_BOTTOM) return 32'sh80000000;
    return coord_t'(s);
  endfunction

  function automatic coord_t sat_sum(input coord_t a, input coord_t b);
    return saturate(longint'(a) + longint'(b));
  endfunction

  function automatic coord_t sat_diff(input coord_t a, input coord_t b);
    return saturate(longint'(a) - longint'(b));
  endfunction

  // absolute coordinate from an argument of the active command
  function automatic coord_t offset(input coord_t base, input coord_t v);
    return cur_rel ? sat_sum(base, v) : v;
  endfunction

  // control point mirrored through the pen
  function automatic coord_t mirror(input coord_t p, input coord_t q);
    return sat_sum(p, sat_diff(p, q));
  endfunction

  function automatic int args_for(input spci_pkg::cmd_t c);
    case (c)
      spci_pkg::CMD_M, spci_pkg::CMD_L, spci_pkg::CMD_T: return 2;
      spci_pkg::CMD_H, spci_pkg::CMD_V:                  return 1;
      spci_pkg::CMD_C:                                   return 6;
      spci_pkg::CMD_S, spci_pkg::CMD_Q:                  return 4;
      spci_pkg::CMD_A:                                   return 7;
      default:                                           return 0;
    endcase
  endfunction

  task automatic clear_state();
    pen_x = '0; pen_y = '0;
    start_x = '0; start_y = '0;
    ctl_x = '0; ctl_y = '0;
    cur_cmd = spci_pkg::CMD_NONE;
    prev_cmd = spci_pkg::CMD_NONE;
    cur_rel = 1'b0;
    collecting = 1'b0;
    n_args = '0;
    foreach (arg_buf[i]) arg_buf[i] = '0;
  endtask

  // an arc keeps only its end point in the first two slots
  task automatic take_arg(input coord_t v);
    int slot;
    slot = int'(n_args);
    if (cur_cmd == spci_pkg::CMD_A) begin
      slot = (n_args >= 3'd5) ? int'(n_args) - 5 : spci_pkg::NUM_ARGS;
    end
    if (slot < spci_pkg::NUM_ARGS) arg_buf[slot] = v;
    n_args = n_args + 3'd1;
  endtask

  // carry out the active command and update the pen
  task automatic draw(output segment_t s);
    spci_pkg::cmd_t c;
    logic refl;
    c = cur_cmd;
    s = '0;
    case (c)
      spci_pkg::CMD_M, spci_pkg::CMD_L, spci_pkg::CMD_A: begin
        s.ex = offset(pen_x, arg_buf[0]);
        s.ey = offset(pen_y, arg_buf[1]);
        s.kind = (c == spci_pkg::CMD_M) ? spci_pkg::SEG_MOVE : spci_pkg::SEG_LINE;
      end
      spci_pkg::CMD_H: begin
        s.ex = offset(pen_x, arg_buf[0]);
        s.ey = pen_y;
        s.kind = spci_pkg::SEG_LINE;
      end
      spci_pkg::CMD_V: begin
        s.ex = pen_x;
        s.ey = offset(pen_y, arg_buf[0]);
        s.kind = spci_pkg::SEG_LINE;
      end
      spci_pkg::CMD_C: begin
        s.c1x = offset(pen_x, arg_buf[0]); s.c1y = offset(pen_y, arg_buf[1]);
        s.c2x = offset(pen_x, arg_buf[2]); s.c2y = offset(pen_y, arg_buf[3]);
        s.ex = offset(pen_x, arg_buf[4]); s.ey = offset(pen_y, arg_buf[5]);
        s.kind = spci_pkg::SEG_CUBIC;
      end
      spci_pkg::CMD_S: begin
        refl = (prev_cmd == spci_pkg::CMD_C) || (prev_cmd == spci_pkg::CMD_S);
        s.c1x = refl ? mirror(pen_x, ctl_x) : pen_x;
        s.c1y = refl ? mirror(pen_y, ctl_y) : pen_y;
        s.c2x = offset(pen_x, arg_buf[0]); s.c2y = offset(pen_y, arg_buf[1]);
        s.ex = offset(pen_x, arg_buf[2]); s.ey = offset(pen_y, arg_buf[3]);
        s.kind = spci_pkg::SEG_CUBIC;
      end
      spci_pkg::CMD_Q: begin
        s.c1x = offset(pen_x, arg_buf[0]); s.c1y = offset(pen_y, arg_buf[1]);
        s.ex = offset(pen_x, arg_buf[2]); s.ey = offset(pen_y, arg_buf[3]);
        s.kind = spci_pkg::SEG_QUAD;
      end
      spci_pkg::CMD_T: begin
        refl = (prev_cmd == spci_pkg::CMD_Q) || (prev_cmd == spci_pkg::CMD_T);
        s.c1x = refl ? mirror(pen_x, ctl_x) : pen_x;
        s.c1y = refl ? mirror(pen_y, ctl_y) : pen_y;
        s.ex = offset(pen_x, arg_buf[0]); s.ey = offset(pen_y, arg_buf[1]);
        s.kind = spci_pkg::SEG_QUAD;
      end
      default: begin
        s.ex = start_x;
        s.ey = start_y;
        s.kind = spci_pkg::SEG_CLOSE;
      end
    endcase
    // control point kept for a later smooth curve
    case (c)
      spci_pkg::CMD_C, spci_pkg::CMD_S: begin ctl_x = s.c2x; ctl_y = s.c2y; end
      spci_pkg::CMD_Q, spci_pkg::CMD_T: begin ctl_x = s.c1x; ctl_y = s.c1y; end
      default:                          begin ctl_x = s.ex; ctl_y = s.ey; end
    endcase
    pen_x = s.ex;
    pen_y = s.ey;
    // a move opens a subpath and repeats as a line
    if (c == spci_pkg::CMD_M) begin
      start_x = s.ex;
      start_y = s.ey;
      cur_cmd = spci_pkg::CMD_L;
    end
    prev_cmd = c;
    collecting = 1'b0;
    n_args = '0;
  endtask

  // one accepted token: queue the segment it completes, if any
  task automatic predict(input logic is_cmd, input spci_pkg::cmd_t code, input logic rel,
                         input coord_t v, input logic last);
    segment_t s;
    logic made;
    made = 1'b0;
    s = '0;
    if (collecting) begin
      // a letter in place of an argument counts as zero
      take_arg(is_cmd ? coord_t'(0) : v);
      if (n_args >= args_for(cur_cmd)) begin
        draw(s);
        made = 1'b1;
      end
    end else if (is_cmd) begin
      cur_cmd = code;
      cur_rel = rel;
      n_args = '0;
      if (code <= spci_pkg::CMD_A) begin
        collecting = 1'b1;
      end else if (code == spci_pkg::CMD_Z) begin
        draw(s);
        made = 1'b1;
      end else begin
        prev_cmd = code;
      end
    end else if (cur_cmd <= spci_pkg::CMD_A) begin
      // implicit repeat of the active command
      collecting = 1'b1;
      n_args = '0;
      take_arg(v);
      if (n_args >= args_for(cur_cmd)) begin
        draw(s);
        made = 1'b1;
      end
    end
    // end of stream: missing arguments are zero, then back to reset
    if (last) begin
      if (collecting) begin
        while (n_args < args_for(cur_cmd)) take_arg('0);
        draw(s);
        made = 1'b1;
      end
      s.stream_end = 1'b1;
      clear_state();
    end
    if (made) seg_q.push_back(s);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  initial clear_state();

  // compare the segment transfer first, then predict from the token transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      seg_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seg_checked <= seg_checked + 1;
        if (seg_q.size() == 0) begin
          fail_count++;
          $display("%0t: segment with none expected, expected nothing, actual kind %0d end %h %h",
                   $time, out_tuser, out_tdata[159:128], out_tdata[191:160]);
        end else begin
          want = seg_q.pop_front();
          check_field("seg_kind", 32'(want.kind), 32'(out_tuser));
          check_field("ctrl1_x", want.c1x, out_tdata[31:0]);
          check_field("ctrl1_y", want.c1y, out_tdata[63:32]);
          check_field("ctrl2_x", want.c2x, out_tdata[95:64]);
          check_field("ctrl2_y", want.c2y, out_tdata[127:96]);
          check_field("end_x", want.ex, out_tdata[159:128]);
          check_field("end_y", want.ey, out_tdata[191:160]);
          check_field("stream_end", 32'(want.stream_end), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        predict(in_tuser[0], in_tdata[3:0], in_tdata[4], in_tdata[36:5], in_tlast);
      end
    end
    seg_waiting <= seg_q.size();
  end

endmodule

[tb/tb_svg_path_command_interpreter.sv]
// testbench top of the svg path command interpreter: token paths, stall patterns and verdict
module tb_svg_path_command_interpreter;

  localparam int TOKEN_TARGET = 1950;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [31:0]    POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]    NEG_MAX = 32'h8000_0000;
  localparam logic [31:0]    ONE     = 32'h0001_0000;
  localparam spci_pkg::cmd_t CMD_UNKNOWN = 4'd13;

  typedef struct packed {
    logic           is_cmd;
    spci_pkg::cmd_t code;
    logic           rel;
    logic [31:0]    value;
    logic           last;
  } token_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [spci_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]                       in_tuser = '0;
  logic                             in_tlast = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [spci_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [spci_pkg::SEG_KIND_W-1:0]  out_tuser;
  logic                             out_tlast;

  int fail_count, seg_waiting, seg_checked;
  int cycle_count = 0;
  int tokens_sent = 0;
  int paths_sent = 0;
  int ready_stall = 0;
  int ready_span = 0;
  logic ready_calm = 1'b0;
  logic in_calm = 1'b0;
  token_t path_q [$];

  svg_path_command_interpreter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  spci_segment_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .seg_waiting (seg_waiting),
    .seg_checked (seg_checked)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit, %0d segments outstanding",
               $time, seg_waiting);
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // segment side stalls, with calm stretches
  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_calm = ($urandom_range(0, 3) == 0);
      ready_span = $urandom_range(50, 300);
    end else begin
      ready_span--;
    end
    if (ready_stall > 0) begin
      ready_stall--;
      out_tready <= 1'b0;
    end else if (!ready_calm && $urandom_range(0, 2) == 0) begin
      ready_stall = pick_gap() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int args_of(input spci_pkg::cmd_t c);
    case (c)
      spci_pkg::CMD_M, spci_pkg::CMD_L, spci_pkg::CMD_T: return 2;
      spci_pkg::CMD_H, spci_pkg::CMD_V:                  return 1;
      spci_pkg::CMD_C:                                   return 6;
      spci_pkg::CMD_S, spci_pkg::CMD_Q:                  return 4;
      spci_pkg::CMD_A:                                   return 7;
      default:                                           return 0;
    endcase
  endfunction

  // coordinates: modest values, full range, near the rails and the rails themselves
  function automatic logic [31:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {{8{r[23]}}, r[23:0]};
      4, 5:       return r;
      6:          return POS_MAX - {24'd0, r[7:0]};
      7:          return NEG_MAX + {24'd0, r[7:0]};
      default: begin
        case (r[2:0])
          3'd0:    return POS_MAX;
          3'd1:    return NEG_MAX;
          3'd2:    return '0;
          3'd3:    return '1;
          3'd4:    return ONE;
          3'd5:    return -ONE;
          default: return {{16{r[31]}}, r[31:16]};
        endcase
      end
    endcase
  endfunction

  function automatic spci_pkg::cmd_t pick_letter();
    if ($urandom_range(0, 99) < 3) return spci_pkg::cmd_t'($urandom_range(10, 15));
    return spci_pkg::cmd_t'($urandom_range(0, 9));
  endfunction

  function automatic logic pick_case();
    return 1'($urandom_range(0, 1));
  endfunction

  // letter token; its value bits are junk
  task automatic add_cmd(input spci_pkg::cmd_t code, input logic rel);
    token_t t;
    t.is_cmd = 1'b1;
    t.code = code;
    t.rel = rel;
    t.value = $urandom;
    t.last = 1'b0;
    path_q.push_back(t);
  endtask

  // number token; its letter and case bits are junk
  task automatic add_num(input logic [31:0] v);
    token_t t;
    t.is_cmd = 1'b0;
    t.code = spci_pkg::cmd_t'($urandom_range(0, 15));
    t.rel = pick_case();
    t.value = v;
    t.last = 1'b0;
    path_q.push_back(t);
  endtask

  // argument groups, now and then with a letter standing in for a number
  task automatic add_args(input spci_pkg::cmd_t code, input int reps);
    repeat (reps) begin
      repeat (args_of(code)) begin
        if ($urandom_range(0, 99) < 4) add_cmd(pick_letter(), pick_case());
        else add_num(pick_value());
      end
    end
  endtask

  // send the queued path, last token marked, with random gaps between transfers
  task automatic send_path();
    token_t t;
    int gap;
    if (path_q.size() == 0) return;
    t = path_q.pop_back();
    t.last = 1'b1;
    path_q.push_back(t);
    foreach (path_q[i]) begin
      gap = (in_calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= {3'b000, path_q[i].value, path_q[i].rel, path_q[i].code};
      in_tuser <= path_q[i].is_cmd;
      in_tlast <= path_q[i].last;
      do @(posedge clk); while (!in_tready);
      tokens_sent++;
    end
    path_q.delete();
    paths_sent++;
  endtask

  task automatic random_path();
    int cut;
    spci_pkg::cmd_t code;
    in_calm = ($urandom_range(0, 3) == 0);
    // numbers ahead of the first command are dropped
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) add_num(pick_value());
    add_cmd(spci_pkg::CMD_M, pick_case());
    add_args(spci_pkg::CMD_M, $urandom_range(1, 2));
    repeat ($urandom_range(1, 10)) begin
      code = pick_letter();
      add_cmd(code, pick_case());
      if (code >= spci_pkg::CMD_Z) begin
        // stray numbers after a close or an unknown letter
        if ($urandom_range(0, 4) == 0) add_num(pick_value());
      end else begin
        add_args(code, ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1);
      end
    end
    // stream end mostly clean, sometimes mid-arguments or on a lone letter
    case ($urandom_range(0, 9))
      0, 1: begin
        cut = $urandom_range(1, 3);
        while (cut > 0 && path_q.size() > 1) begin
          void'(path_q.pop_back());
          cut--;
        end
      end
      2:       add_cmd(pick_letter(), pick_case());
      default: ;
    endcase
    send_path();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // number before any command, corner move, saturating relative line, cubic with a
    // letter in an argument slot, close, stray number as the last token
    add_num(32'd5);
    add_cmd(spci_pkg::CMD_M, 1'b0);
    add_num(POS_MAX);
    add_num(NEG_MAX);
    add_cmd(spci_pkg::CMD_L, 1'b1);
    add_num(POS_MAX);
    add_num(NEG_MAX);
    add_cmd(spci_pkg::CMD_C, 1'b0);
    add_cmd(spci_pkg::CMD_A, 1'b1);
    repeat (5) add_num(pick_value());
    add_cmd(spci_pkg::CMD_Z, 1'b0);
    add_num(3 * ONE);
    send_path();

    // unknown letter, smooth curves with nothing to reflect, h and v, arc cut short
    add_cmd(CMD_UNKNOWN, 1'b0);
    add_cmd(spci_pkg::CMD_S, 1'b1);
    repeat (4) add_num(pick_value());
    add_cmd(spci_pkg::CMD_T, 1'b0);
    add_num(-ONE);
    add_num(ONE);
    add_cmd(spci_pkg::CMD_H, 1'b1);
    add_num('1);
    add_cmd(spci_pkg::CMD_V, 1'b0);
    add_num(NEG_MAX);
    add_cmd(spci_pkg::CMD_A, 1'b1);
    repeat (3) add_num(pick_value());
    send_path();

    while (tokens_sent < TOKEN_TARGET) random_path();
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;

    // drain
    do @(posedge clk); while (seg_waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d tokens in %0d paths with random gaps and stalls", tokens_sent,
             paths_sent);
    $display("compared %0d segments, %0d mismatches", seg_checked, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/spci_pkg.sv
hw/rtl/spci_queue.sv
hw/rtl/spci_front.sv
hw/rtl/spci_back.sv
hw/rtl/svg_path_command_interpreter.sv
tb/spci_segment_checker.sv
tb/tb_svg_path_command_interpreter.sv
